FILE: src/packet_deframer_crc16_check_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packet deframer
// Shorthands for clocked implication checks with reset masking.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_CRC16_CHECK_MACROS_SVH
`define PACKET_DEFRAMER_CRC16_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PDC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pdc_pkg.sv
// ----------------------------------------------------------------------------
// Packet deframer package
// Shared types, constants and the bytewise CRC-16 step.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam logic [7:0]  MARKER_BYTE     = 8'h55;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_TOP         = 16'h8000;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd132;
    localparam logic [3:0]  HDR_LAST_IDX    = 4'd8;
    localparam logic [3:0]  HDR_CRC_IDX_END = 4'd7;
    localparam int          REQ_FIFO_DEPTH  = 4;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_HDR_CRC  = 2'd1,
        ST_PAY_CRC  = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    // START opens a payload, END closes a packet without payload, DATA moves
    // one payload byte.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_END   = 2'd1,
        OP_DATA  = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic        last;
        status_t     status;
        logic [7:0]  pkt_type;
        logic [7:0]  address;
        logic [7:0]  pkt_flags;
        logic [15:0] length;
        logic [15:0] data_check;
    } entry_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    localparam logic [15:0] HDR_CRC_SEED = crc16_byte(CRC_INIT, MARKER_BYTE);

endpackage

FILE: src/pdc_front.sv
// ----------------------------------------------------------------------------
// Packet deframer front end
// Hunts for the marker, collects and checks the header, counts the payload
// and turns each payload byte and each completed header into a request for the back end.
// ----------------------------------------------------------------------------
module pdc_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [15:0]      cfg_data,
    input  logic             q_full,
    output logic             q_push,
    output pdc_pkg::entry_t  q_entry
);
    import pdc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] max_len_reg;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] dchk_reg, dchk_next;
    logic [7:0]  hchk_lo_reg, hchk_lo_next;

    logic        accept;
    logic [3:0]  idx;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign idx       = (count_reg > HDR_LAST_IDX) ? HDR_LAST_IDX : count_reg;

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        left_next    = left_reg;
        type_next    = type_reg;
        addr_next    = addr_reg;
        flags_next   = flags_reg;
        len_next     = len_reg;
        dchk_next    = dchk_reg;
        hchk_lo_next = hchk_lo_reg;
        q_push       = 1'b0;

        q_entry.op         = OP_DATA;
        q_entry.data       = s_rx_byte;
        q_entry.last       = 1'b0;
        q_entry.status     = ST_OK;
        q_entry.pkt_type   = type_reg;
        q_entry.address    = addr_reg;
        q_entry.pkt_flags  = flags_reg;
        q_entry.length     = len_reg;
        q_entry.data_check = dchk_reg;

        if (accept) begin
            case (phase_reg)
                PH_HEADER: begin
                    case (idx)
                        4'd0:    type_next         = s_rx_byte;
                        4'd1:    addr_next         = s_rx_byte;
                        4'd2:    flags_next        = s_rx_byte;
                        4'd3:    len_next[7:0]     = s_rx_byte;
                        4'd4:    len_next[15:8]    = s_rx_byte;
                        4'd5:    dchk_next[7:0]    = s_rx_byte;
                        4'd6:    dchk_next[15:8]   = s_rx_byte;
                        4'd7:    hchk_lo_next      = s_rx_byte;
                        default: hchk_lo_next      = hchk_lo_reg;
                    endcase
                    if (idx < HDR_CRC_IDX_END) begin
                        crc_next = crc16_byte(crc_reg, s_rx_byte);
                    end
                    count_next = idx + 4'd1;
                    if (idx == HDR_LAST_IDX) begin
                        // The final header byte is the upper half of the header check.
                        q_push     = 1'b1;
                        count_next = 4'd0;
                        phase_next = PH_HUNT;
                        crc_next   = CRC_INIT;
                        q_entry.op   = OP_END;
                        q_entry.data = 8'h00;
                        q_entry.last = 1'b1;
                        if (crc_reg != {s_rx_byte, hchk_lo_reg}) begin
                            q_entry.status = ST_HDR_CRC;
                        end else if (len_reg > max_len_reg) begin
                            q_entry.status = ST_TOO_LONG;
                        end else if (len_reg == 16'd0) begin
                            q_entry.status = (dchk_reg == CRC_INIT) ? ST_OK : ST_PAY_CRC;
                        end else begin
                            q_entry.op   = OP_START;
                            q_entry.last = 1'b0;
                            left_next    = len_reg;
                            phase_next   = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    q_push       = 1'b1;
                    left_next    = left_reg - 16'd1;
                    q_entry.last = (left_reg == 16'd1);
                    if (left_reg == 16'd1) begin
                        phase_next = PH_HUNT;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    if (s_rx_byte == MARKER_BYTE) begin
                        crc_next   = HDR_CRC_SEED;
                        count_next = 4'd0;
                        phase_next = PH_HEADER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            count_reg   <= 4'd0;
            crc_reg     <= CRC_INIT;
            left_reg    <= 16'd0;
            max_len_reg <= MAX_LEN_RESET;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            left_reg  <= left_next;
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        type_reg    <= type_next;
        addr_reg    <= addr_next;
        flags_reg   <= flags_next;
        len_reg     <= len_next;
        dchk_reg    <= dchk_next;
        hchk_lo_reg <= hchk_lo_next;
    end

endmodule

FILE: src/pdc_queue.sv
// ----------------------------------------------------------------------------
// Packet deframer request queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module pdc_queue #(
    parameter int DEPTH = pdc_pkg::REQ_FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pdc_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output pdc_pkg::entry_t  head
);
    import pdc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: src/pdc_back.sv
// ----------------------------------------------------------------------------
// Packet deframer back end
// Runs the payload CRC, holds the packet's header fields and drives the
// registered result port.
// ----------------------------------------------------------------------------
module pdc_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  pdc_pkg::entry_t  q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_has_data,
    output logic [7:0]       m_data_byte,
    output logic             m_last,
    output logic [7:0]       m_pkt_type,
    output logic [7:0]       m_address,
    output logic [7:0]       m_pkt_flags,
    output logic [15:0]      m_length,
    output logic [1:0]       m_status
);
    import pdc_pkg::*;

    logic        valid_reg, valid_next;
    logic        has_reg, has_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;
    logic [7:0]  otype_reg, otype_next;
    logic [7:0]  oaddr_reg, oaddr_next;
    logic [7:0]  oflags_reg, oflags_next;
    logic [15:0] olen_reg, olen_next;
    status_t     status_reg, status_next;

    logic [7:0]  type_reg, type_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] dchk_reg, dchk_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] crc_step;

    // A payload start carries no result and may pass a stalled output.
    assign q_pop    = q_valid && (q_head.op == OP_START || !valid_reg || m_ready);
    assign crc_step = crc16_byte(crc_reg, q_head.data);

    always_comb begin
        valid_next  = valid_reg && !m_ready;
        has_next    = has_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        otype_next  = otype_reg;
        oaddr_next  = oaddr_reg;
        oflags_next = oflags_reg;
        olen_next   = olen_reg;
        status_next = status_reg;
        type_next   = type_reg;
        addr_next   = addr_reg;
        flags_next  = flags_reg;
        len_next    = len_reg;
        dchk_next   = dchk_reg;
        crc_next    = crc_reg;

        if (q_pop) begin
            case (q_head.op)
                OP_START: begin
                    type_next  = q_head.pkt_type;
                    addr_next  = q_head.address;
                    flags_next = q_head.pkt_flags;
                    len_next   = q_head.length;
                    dchk_next  = q_head.data_check;
                    crc_next   = CRC_INIT;
                end
                OP_END: begin
                    valid_next  = 1'b1;
                    has_next    = 1'b0;
                    data_next   = 8'h00;
                    last_next   = 1'b1;
                    otype_next  = q_head.pkt_type;
                    oaddr_next  = q_head.address;
                    oflags_next = q_head.pkt_flags;
                    olen_next   = q_head.length;
                    status_next = q_head.status;
                end
                default: begin
                    valid_next  = 1'b1;
                    has_next    = 1'b1;
                    data_next   = q_head.data;
                    last_next   = q_head.last;
                    otype_next  = type_reg;
                    oaddr_next  = addr_reg;
                    oflags_next = flags_reg;
                    olen_next   = len_reg;
                    crc_next    = crc_step;
                    status_next = ST_OK;
                    if (q_head.last) begin
                        status_next = (crc_step == dchk_reg) ? ST_OK : ST_PAY_CRC;
                        crc_next    = CRC_INIT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            crc_reg   <= CRC_INIT;
        end else begin
            valid_reg <= valid_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        has_reg    <= has_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
        otype_reg  <= otype_next;
        oaddr_reg  <= oaddr_next;
        oflags_reg <= oflags_next;
        olen_reg   <= olen_next;
        status_reg <= status_next;
        type_reg   <= type_next;
        addr_reg   <= addr_next;
        flags_reg  <= flags_next;
        len_reg    <= len_next;
        dchk_reg   <= dchk_next;
    end

    assign m_valid     = valid_reg;
    assign m_has_data  = has_reg;
    assign m_data_byte = data_reg;
    assign m_last      = last_reg;
    assign m_pkt_type  = otype_reg;
    assign m_address   = oaddr_reg;
    assign m_pkt_flags = oflags_reg;
    assign m_length    = olen_reg;
    assign m_status    = status_reg;

endmodule

FILE: src/packet_deframer_crc16_check.sv
// ----------------------------------------------------------------------------
// Marker-framed packet receiver with CRC-16 checks
// Deframes a byte stream into header fields, payload bytes and a status.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while the request queue
// has room, and gives at most one result per byte. A byte passes through the
// front end combinationally and lands in a request queue of REQ_FIFO_DEPTH
// entries at the edge that accepts it; the back end then moves it into the
// output register once that register is empty or being taken. s_ready
// drops only while that queue is full, which happens when the result port is
// stalled. The header check is done in the front end and the payload CRC in
// the back end, each a combinational bytewise CRC step. The length limit may
// be written at any time; cfg_ready is always high.
`include "packet_deframer_crc16_check_macros.svh"

module packet_deframer_crc16_check #(
    parameter int REQ_FIFO_DEPTH = pdc_pkg::REQ_FIFO_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_rx_byte,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_has_data,
    output logic [7:0]   m_data_byte,
    output logic         m_last,
    output logic [7:0]   m_pkt_type,
    output logic [7:0]   m_address,
    output logic [7:0]   m_pkt_flags,
    output logic [15:0]  m_length,
    output logic [1:0]   m_status
);
    import pdc_pkg::*;

    logic   q_full;
    logic   q_push;
    entry_t q_in;
    logic   q_pop;
    logic   q_valid;
    entry_t q_head;

    pdc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    pdc_queue #(
        .DEPTH (REQ_FIFO_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    pdc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_has_data  (m_has_data),
        .m_data_byte (m_data_byte),
        .m_last      (m_last),
        .m_pkt_type  (m_pkt_type),
        .m_address   (m_address),
        .m_pkt_flags (m_pkt_flags),
        .m_length    (m_length),
        .m_status    (m_status)
    );

    // A result without a payload byte always closes its packet.
    `PDC_ASSERT_SAME(a_no_data_is_last, aclk, aresetn, m_valid && !m_has_data,
                     m_last && (m_data_byte == 8'h00), "result without data is not last")

    // Status is only reported on the final result of a packet.
    `PDC_ASSERT_SAME(a_status_on_last, aclk, aresetn, m_valid && !m_last,
                     m_status == ST_OK, "status set on a result that is not last")

    // A pushed request is never dropped: the front end only pushes when there is room.
    `PDC_ASSERT_SAME(a_push_has_room, aclk, aresetn, q_push, !q_full,
                     "request pushed into a full queue")

endmodule
